// ----- design/crie_pkg.sv -----
// crie_pkg: shared constants, request types and codes for the interval expander.
// Used by crie_frac_div, crie_cfg_regs and competing_risk_interval_expander.
package crie_pkg;

  localparam int MAX_BINS      = 7;
  localparam int TIME_BITS     = 32;
  localparam int FRACTION_BITS = 16;

  localparam int FRAC_W      = FRACTION_BITS + 1;
  localparam int REC_W       = 32;
  localparam int KIND_W      = 8;
  localparam int BIN_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = TIME_BITS;
  localparam int EDGE_IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int DIV_CNT_W   = $clog2(FRACTION_BITS + 1);
  localparam int EDGE_STEP   = 1000000;
  localparam int BINS_RESET  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = CFG_IDX_W'(0);

  localparam logic [KIND_W-1:0] KIND_CENSORED = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_FILL     = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_ACK      = KIND_W'(2);

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_KIND  = 2'd1;
  localparam logic [1:0] ERR_EDGES = 2'd2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef struct packed {
    logic [TIME_BITS-1:0] duration;
    logic [KIND_W-1:0]    kind_code;
  } in_req_t;

  typedef struct packed {
    logic [REC_W-1:0]     record_number;
    logic [BIN_W-1:0]     bin_number;
    logic [TIME_BITS-1:0] interval_start;
    logic [TIME_BITS-1:0] interval_end;
    logic [FRAC_W-1:0]    bin_share;
    logic                 fill_event;
    logic                 ack_event;
    logic                 last_of_run;
    logic [1:0]           error_code;
  } out_req_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_BIN   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

endpackage

// ----- design/competing_risk_interval_expander.sv -----
// competing_risk_interval_expander: top level, sequencer and output register.
// Depends on crie_pkg, crie_cfg_regs and crie_frac_div.
//
// Each request on in_ (duration, event kind) is split into one result per
// time bin on out_, up to the bin that holds the end of observation; the
// final result carries last_of_run. A bad edge table or kind gives a single
// error result. Both channels are valid/ready; cfg_ is a plain write port,
// written only while the block is idle, a rule on the user that the block has no check for.
// Steps: ST_IDLE takes the request, then ST_CHECK walks the edge table one
// edge per cycle. Each bin then passes ST_BIN (set-up), ST_DIV (the
// bit-serial divider, cut short when the bin is fully exposed) and ST_OUT
// (into the output register, where a stalled receiver holds it). Only the
// final bin can be partly exposed, so only it needs the full division.
// A new request is taken once the last result of the previous one sits in
// the output register, while it still waits for out_ready.
// A stalled receiver holds the output register and the sequencer waits.
// Reset (rst_n low, synchronous) restores the register defaults, empties
// the output register and clears the record counter.
module competing_risk_interval_expander (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  crie_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output crie_pkg::out_req_t              out_data,
  input  logic                            cfg_we,
  input  logic [crie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crie_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  crie_pkg::state_t state_r, state_nxt;
  logic [crie_pkg::BIN_W-1:0]     idx_r, idx_nxt;
  logic [crie_pkg::TIME_BITS-1:0] prev_r, prev_nxt;
  logic [crie_pkg::TIME_BITS-1:0] obs_r, obs_nxt;
  logic [crie_pkg::TIME_BITS-1:0] dur_r, dur_nxt;
  logic [crie_pkg::KIND_W-1:0]    kind_r, kind_nxt;
  logic                           evt_r, evt_nxt;
  logic [crie_pkg::REC_W-1:0]     rec_cnt_r, rec_cnt_nxt;
  logic [crie_pkg::REC_W-1:0]     rec_r, rec_nxt;
  crie_pkg::out_req_t             res_r, res_nxt;
  crie_pkg::out_req_t             out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic [crie_pkg::TIME_BITS-1:0] edge_rd;
  logic [crie_pkg::BIN_W-1:0]     bins_used;
  logic [crie_pkg::BIN_W-1:0]     last_idx;
  logic [crie_pkg::TIME_BITS-1:0] top;
  logic [crie_pkg::TIME_BITS-1:0] exposed;
  logic [crie_pkg::TIME_BITS-1:0] span;
  logic                           is_evt;
  logic                           is_last;
  logic                           div_start;
  logic                           div_done;
  logic [crie_pkg::FRAC_W-1:0]    div_q;
  logic                           in_acc;

  crie_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rd_idx    (idx_r[crie_pkg::EDGE_IDX_W-1:0]),
    .rd_edge   (edge_rd),
    .bins_used (bins_used)
  );

  crie_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (exposed),
    .den   (span),
    .done  (div_done),
    .quot  (div_q)
  );

  assign in_ready  = (state_r == crie_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign last_idx  = bins_used - 1'b1;
  assign top       = (obs_r < edge_rd) ? obs_r : edge_rd;
  assign exposed   = (top > prev_r) ? (top - prev_r) : '0;
  assign span      = edge_rd - prev_r;
  assign is_evt    = evt_r && (dur_r <= edge_rd);
  assign is_last   = is_evt || (obs_r <= edge_rd);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    obs_nxt       = obs_r;
    dur_nxt       = dur_r;
    kind_nxt      = kind_r;
    evt_nxt       = evt_r;
    rec_cnt_nxt   = rec_cnt_r;
    rec_nxt       = rec_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_start     = 1'b0;

    case (state_r)
      crie_pkg::ST_IDLE: begin
        if (in_acc) begin
          dur_nxt     = in_data.duration;
          kind_nxt    = in_data.kind_code;
          rec_nxt     = rec_cnt_r;
          rec_cnt_nxt = rec_cnt_r + 1'b1;
          idx_nxt     = '0;
          prev_nxt    = '0;
          if (bins_used == '0) begin
            res_nxt               = '0;
            res_nxt.record_number = rec_cnt_r;
            res_nxt.last_of_run   = 1'b1;
            res_nxt.error_code    = crie_pkg::ERR_EDGES;
            state_nxt             = crie_pkg::ST_OUT;
          end else begin
            state_nxt = crie_pkg::ST_CHECK;
          end
        end
      end
      crie_pkg::ST_CHECK: begin
        if (!(edge_rd > prev_r)) begin
          res_nxt               = '0;
          res_nxt.record_number = rec_r;
          res_nxt.last_of_run   = 1'b1;
          res_nxt.error_code    = crie_pkg::ERR_EDGES;
          state_nxt             = crie_pkg::ST_OUT;
        end else if (idx_r == last_idx) begin
          if (kind_r > crie_pkg::KIND_ACK) begin
            res_nxt               = '0;
            res_nxt.record_number = rec_r;
            res_nxt.last_of_run   = 1'b1;
            res_nxt.error_code    = crie_pkg::ERR_KIND;
            state_nxt             = crie_pkg::ST_OUT;
          end else begin
            obs_nxt   = (dur_r < edge_rd) ? dur_r : edge_rd;
            evt_nxt   = (kind_r != crie_pkg::KIND_CENSORED) && (dur_r <= edge_rd);
            idx_nxt   = '0;
            prev_nxt  = '0;
            state_nxt = crie_pkg::ST_BIN;
          end
        end else begin
          prev_nxt = edge_rd;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      crie_pkg::ST_BIN: begin
        if (exposed == '0 && !is_evt) begin
          state_nxt = crie_pkg::ST_IDLE;
        end else begin
          res_nxt.record_number  = rec_r;
          res_nxt.bin_number     = idx_r;
          res_nxt.interval_start = prev_r;
          res_nxt.interval_end   = edge_rd;
          res_nxt.bin_share      = '0;
          res_nxt.fill_event     = is_evt && (kind_r == crie_pkg::KIND_FILL);
          res_nxt.ack_event      = is_evt && (kind_r == crie_pkg::KIND_ACK);
          res_nxt.last_of_run    = is_last;
          res_nxt.error_code     = crie_pkg::ERR_NONE;
          div_start              = 1'b1;
          state_nxt              = crie_pkg::ST_DIV;
        end
      end
      crie_pkg::ST_DIV: begin
        if (div_done) begin
          res_nxt.bin_share = div_q;
          state_nxt         = crie_pkg::ST_OUT;
        end
      end
      crie_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          if (res_r.last_of_run) begin
            state_nxt = crie_pkg::ST_IDLE;
          end else begin
            prev_nxt  = res_r.interval_end;
            idx_nxt   = idx_r + 1'b1;
            state_nxt = crie_pkg::ST_BIN;
          end
        end
      end
      default: begin
        state_nxt = crie_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crie_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      rec_cnt_r   <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    obs_r  <= obs_nxt;
    dur_r  <= dur_nxt;
    kind_r <= kind_nxt;
    evt_r  <= evt_nxt;
    rec_r  <= rec_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.bin_share <= crie_pkg::FRAC_ONE))
    else $error("exposure fraction above one");

  a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.fill_event || out_data.ack_event)) |->
      (out_data.last_of_run && !(out_data.fill_event && out_data.ack_event)))
    else $error("event flag off the final result");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code != crie_pkg::ERR_NONE) |->
      (out_data.last_of_run && out_data.bin_share == '0 &&
       out_data.interval_end == '0))
    else $error("error result with bin fields set");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == crie_pkg::ST_DIV))
    else $error("divider finished outside its wait state");

endmodule

// ----- design/crie_frac_div.sv -----
// crie_frac_div: bit-serial restoring divider, one quotient bit per cycle.
// Gives floor(num * 2^FRACTION_BITS / den), saturated at one. Uses crie_pkg.
module crie_frac_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [crie_pkg::TIME_BITS-1:0] num,
  input  logic [crie_pkg::TIME_BITS-1:0] den,
  output logic                           done,
  output logic [crie_pkg::FRAC_W-1:0]    quot
);

  logic                           busy_r;
  logic                           done_r;
  logic [crie_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [crie_pkg::TIME_BITS-1:0] rem_r;
  logic [crie_pkg::TIME_BITS-1:0] den_r;
  logic [crie_pkg::FRAC_W-1:0]    quot_r;
  logic [crie_pkg::TIME_BITS:0]   rem_sh;
  logic [crie_pkg::TIME_BITS:0]   rem_sub;
  logic                           take;

  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign take    = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (num >= den) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= crie_pkg::DIV_CNT_W'(crie_pkg::FRACTION_BITS);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == crie_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r  <= den;
      rem_r  <= num;
      quot_r <= (num >= den) ? crie_pkg::FRAC_ONE : '0;
    end else if (busy_r) begin
      rem_r  <= take ? rem_sub[crie_pkg::TIME_BITS-1:0] : rem_sh[crie_pkg::TIME_BITS-1:0];
      quot_r <= {quot_r[crie_pkg::FRAC_W-2:0], take};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- design/crie_cfg_regs.sv -----
// crie_cfg_regs: bin count and bin edge registers with one read port.
// Write-only configuration port; uses crie_pkg.
module crie_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [crie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crie_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [crie_pkg::EDGE_IDX_W-1:0] rd_idx,
  output logic [crie_pkg::TIME_BITS-1:0]  rd_edge,
  output logic [crie_pkg::BIN_W-1:0]      bins_used
);

  logic [crie_pkg::BIN_W-1:0]     bins_r;
  logic [crie_pkg::TIME_BITS-1:0] edges_r [crie_pkg::MAX_BINS];
  logic [crie_pkg::CFG_IDX_W-1:0] edge_no;

  assign edge_no = cfg_index - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= crie_pkg::BIN_W'(crie_pkg::BINS_RESET);
      for (int i = 0; i < crie_pkg::MAX_BINS; i++) begin
        edges_r[i] <= crie_pkg::TIME_BITS'(crie_pkg::EDGE_STEP * (i + 1));
      end
    end else if (cfg_we) begin
      if (cfg_index == crie_pkg::CFG_BINS_IN_USE) begin
        bins_r <= cfg_wdata[crie_pkg::BIN_W-1:0];
      end else if (int'(edge_no) < crie_pkg::MAX_BINS) begin
        edges_r[edge_no[crie_pkg::EDGE_IDX_W-1:0]] <= cfg_wdata[crie_pkg::TIME_BITS-1:0];
      end
    end
  end

  assign rd_edge   = edges_r[rd_idx];
  assign bins_used = (int'(bins_r) > crie_pkg::MAX_BINS) ?
                     crie_pkg::BIN_W'(crie_pkg::MAX_BINS) : bins_r;

endmodule
